[src/rgbhsv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared defaults, pipeline constants and codes for the converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Default widths of one color component and of the hue result.
  localparam int COMPONENT_BITS_DEF = 8;
  localparam int HUE_BITS_DEF       = 16;

  // Number of quotient bits each divider stage resolves.
  localparam int STEPS_PER_STAGE = 2;

  // Which component holds the largest value (red wins ties, then green).
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

endpackage : rgbhsv_pkg
`default_nettype wire

[src/rgbhsv_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter stream interfaces
// Valid/ready channels for the incoming pixel and the outgoing HSV result.
// ----------------------------------------------------------------------------

// One pixel beat: three unsigned color components.
interface rgbhsv_pix_if #(
  parameter int COMPONENT_BITS = 8
);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red_in;
  logic [COMPONENT_BITS-1:0] green_in;
  logic [COMPONENT_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface : rgbhsv_pix_if

// One result beat: hue, saturation and value.
interface rgbhsv_hsv_if #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 16
);
  logic                      valid;
  logic                      ready;
  logic [HUE_BITS-1:0]       hue_out;
  logic [COMPONENT_BITS-1:0] saturation_out;
  logic [COMPONENT_BITS-1:0] value_out;

  modport source (output valid, output hue_out, output saturation_out,
                  output value_out, input ready);
  modport sink   (input valid, input hue_out, input saturation_out,
                  input value_out, output ready);
endinterface : rgbhsv_hsv_if
`default_nettype wire

[src/rgbhsv_div_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV divider stage
// One register stage of the two restoring dividers (hue and saturation).
// Each stage resolves a fixed number of quotient bits and passes partial
// remainders, divisors and quotients on to the next stage.
// ----------------------------------------------------------------------------
module rgbhsv_div_stage
  import rgbhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int HUE_BITS       = HUE_BITS_DEF,
  parameter int FIRST_STEP     = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [COMPONENT_BITS+2:0]   in_hue_rem,
  input  wire logic [COMPONENT_BITS+2:0]   in_hue_den,
  input  wire logic [HUE_BITS-1:0]         in_hue_quo,
  input  wire logic [COMPONENT_BITS-1:0]   in_sat_rem,
  input  wire logic [COMPONENT_BITS-1:0]   in_sat_low,
  input  wire logic [COMPONENT_BITS-1:0]   in_sat_div,
  input  wire logic [COMPONENT_BITS-1:0]   in_sat_quo,
  input  wire logic [COMPONENT_BITS-1:0]   in_value,

  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [COMPONENT_BITS+2:0]        out_hue_rem,
  output logic [COMPONENT_BITS+2:0]        out_hue_den,
  output logic [HUE_BITS-1:0]              out_hue_quo,
  output logic [COMPONENT_BITS-1:0]        out_sat_rem,
  output logic [COMPONENT_BITS-1:0]        out_sat_low,
  output logic [COMPONENT_BITS-1:0]        out_sat_div,
  output logic [COMPONENT_BITS-1:0]        out_sat_quo,
  output logic [COMPONENT_BITS-1:0]        out_value
);

  localparam int RW = COMPONENT_BITS + 3;
  localparam int C  = COMPONENT_BITS;

  logic          v_r;
  logic [RW-1:0] hue_rem_r, hue_den_r;
  logic [HUE_BITS-1:0] hue_quo_r;
  logic [C-1:0]  sat_rem_r, sat_low_r, sat_div_r, sat_quo_r, value_r;

  logic [RW-1:0] hue_rem_nxt;
  logic [HUE_BITS-1:0] hue_quo_nxt;
  logic [C-1:0]  sat_rem_nxt, sat_low_nxt, sat_quo_nxt;

  // The stage takes a new beat when it is empty or its beat moves on.
  assign in_ready = !v_r || out_ready;

  // Restoring division steps for both quotients.
  always_comb begin
    logic [RW:0] hue_sh;
    logic [C:0]  sat_sh;
    hue_sh      = '0;
    sat_sh      = '0;
    hue_rem_nxt = in_hue_rem;
    hue_quo_nxt = in_hue_quo;
    sat_rem_nxt = in_sat_rem;
    sat_low_nxt = in_sat_low;
    sat_quo_nxt = in_sat_quo;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      if (FIRST_STEP + k < HUE_BITS) begin
        hue_sh = {hue_rem_nxt, 1'b0};
        if (hue_sh >= {1'b0, in_hue_den}) begin
          hue_rem_nxt = RW'(hue_sh - {1'b0, in_hue_den});
          hue_quo_nxt = {hue_quo_nxt[HUE_BITS-2:0], 1'b1};
        end else begin
          hue_rem_nxt = hue_sh[RW-1:0];
          hue_quo_nxt = {hue_quo_nxt[HUE_BITS-2:0], 1'b0};
        end
      end
      if (FIRST_STEP + k < C) begin
        sat_sh      = {sat_rem_nxt, sat_low_nxt[C-1]};
        sat_low_nxt = {sat_low_nxt[C-2:0], 1'b0};
        if (sat_sh >= {1'b0, in_sat_div}) begin
          sat_rem_nxt = C'(sat_sh - {1'b0, in_sat_div});
          sat_quo_nxt = {sat_quo_nxt[C-2:0], 1'b1};
        end else begin
          sat_rem_nxt = sat_sh[C-1:0];
          sat_quo_nxt = {sat_quo_nxt[C-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // Payload registers load only with an incoming beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hue_rem_r <= hue_rem_nxt;
      hue_den_r <= in_hue_den;
      hue_quo_r <= hue_quo_nxt;
      sat_rem_r <= sat_rem_nxt;
      sat_low_r <= sat_low_nxt;
      sat_div_r <= in_sat_div;
      sat_quo_r <= sat_quo_nxt;
      value_r   <= in_value;
    end
  end

  assign out_valid   = v_r;
  assign out_hue_rem = hue_rem_r;
  assign out_hue_den = hue_den_r;
  assign out_hue_quo = hue_quo_r;
  assign out_sat_rem = sat_rem_r;
  assign out_sat_low = sat_low_r;
  assign out_sat_div = sat_div_r;
  assign out_sat_quo = sat_quo_r;
  assign out_value   = value_r;

endmodule : rgbhsv_div_stage
`default_nettype wire

[src/rgb_to_hsv_converter_core.sv]
`default_nettype none
// Throughput: one pixel per cycle unless the output stalls.
// Each divider stage resolves two quotient bits.
// A stalled output holds every stage that is full; empty stages still fill.
// Reset (synchronous, rst_n low) clears all valid bits; data registers keep their values.
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Pipelined pixel converter: max/min search, hue and saturation setup, then
// a chain of restoring divider stages that produce hue and saturation.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core
  import rgbhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int HUE_BITS       = HUE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  rgbhsv_pix_if.sink    in_pix,
  rgbhsv_hsv_if.source  out_hsv
);

  localparam int C     = COMPONENT_BITS;
  localparam int RW    = COMPONENT_BITS + 3;
  localparam int NW    = COMPONENT_BITS + 4;
  localparam int NSTEP = (HUE_BITS > COMPONENT_BITS) ? HUE_BITS : COMPONENT_BITS;
  localparam int ND    = (NSTEP + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Stage 1: registered components with their maximum, minimum and winner.
  logic         v1_r;
  logic [C-1:0] r1_r, g1_r, b1_r, hi1_r, lo1_r;
  max_sel_t     sel1_r;
  logic [C-1:0] hi1_nxt, lo1_nxt;
  max_sel_t     sel1_nxt;

  // Stage 2: divider operands.
  logic          v2_r;
  logic [RW-1:0] hue_rem2_r, hue_den2_r;
  logic [C-1:0]  sat_rem2_r, sat_low2_r, sat_div2_r, value2_r;
  logic [RW-1:0] hue_rem2_nxt, hue_den2_nxt;
  logic [C-1:0]  sat_rem2_nxt, sat_low2_nxt, sat_div2_nxt;

  logic adv1, adv2;

  // Divider chain links; index 0 feeds the first stage.
  logic                v_a       [0:ND];
  logic                rdy_a     [0:ND];
  logic [RW-1:0]       hue_rem_a [0:ND];
  logic [RW-1:0]       hue_den_a [0:ND];
  logic [HUE_BITS-1:0] hue_quo_a [0:ND];
  logic [C-1:0]        sat_rem_a [0:ND];
  logic [C-1:0]        sat_low_a [0:ND];
  logic [C-1:0]        sat_div_a [0:ND];
  logic [C-1:0]        sat_quo_a [0:ND];
  logic [C-1:0]        value_a   [0:ND];

  // Stage handshakes: a stage advances when empty or when its beat moves on.
  assign adv2         = !v2_r || rdy_a[0];
  assign adv1         = !v1_r || adv2;
  assign in_pix.ready = adv1;

  // Largest and smallest component; red wins ties, then green.
  always_comb begin
    hi1_nxt  = in_pix.red_in;
    lo1_nxt  = in_pix.red_in;
    if (in_pix.green_in > hi1_nxt) hi1_nxt = in_pix.green_in;
    if (in_pix.blue_in  > hi1_nxt) hi1_nxt = in_pix.blue_in;
    if (in_pix.green_in < lo1_nxt) lo1_nxt = in_pix.green_in;
    if (in_pix.blue_in  < lo1_nxt) lo1_nxt = in_pix.blue_in;
    if (hi1_nxt == in_pix.red_in) begin
      sel1_nxt = SEL_RED;
    end else if (hi1_nxt == in_pix.green_in) begin
      sel1_nxt = SEL_GREEN;
    end else begin
      sel1_nxt = SEL_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.valid && adv1) begin
      r1_r   <= in_pix.red_in;
      g1_r   <= in_pix.green_in;
      b1_r   <= in_pix.blue_in;
      hi1_r  <= hi1_nxt;
      lo1_r  <= lo1_nxt;
      sel1_r <= sel1_nxt;
    end
  end

  // Hue numerator and denominator, saturation dividend split into halves.
  // A zero divisor is replaced by all ones so that the quotient comes out zero.
  always_comb begin
    logic [C-1:0]        delta;
    logic signed [NW-1:0] r_s, g_s, b_s, d_s, num_s;
    logic [2*C-1:0]      sat_num;
    delta = hi1_r - lo1_r;
    r_s   = signed'({4'b0000, r1_r});
    g_s   = signed'({4'b0000, g1_r});
    b_s   = signed'({4'b0000, b1_r});
    d_s   = signed'({4'b0000, delta});
    case (sel1_r)
      SEL_RED:   num_s = g_s - b_s;
      SEL_GREEN: num_s = (d_s <<< 1) + b_s - r_s;
      SEL_BLUE:  num_s = (d_s <<< 2) + r_s - g_s;
      default:   num_s = '0;
    endcase
    if (num_s < 0) begin
      num_s = num_s + (d_s <<< 2) + (d_s <<< 1);
    end
    hue_rem2_nxt = num_s[RW-1:0];
    hue_den2_nxt = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    if (delta == '0) begin
      hue_den2_nxt = '1;
    end
    sat_num      = {delta, {C{1'b0}}} - {{C{1'b0}}, delta};
    sat_rem2_nxt = sat_num[2*C-1:C];
    sat_low2_nxt = sat_num[C-1:0];
    sat_div2_nxt = (hi1_r == '0) ? '1 : hi1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && adv2) begin
      hue_rem2_r <= hue_rem2_nxt;
      hue_den2_r <= hue_den2_nxt;
      sat_rem2_r <= sat_rem2_nxt;
      sat_low2_r <= sat_low2_nxt;
      sat_div2_r <= sat_div2_nxt;
      value2_r   <= hi1_r;
    end
  end

  // Feed of the divider chain.
  assign v_a[0]       = v2_r;
  assign hue_rem_a[0] = hue_rem2_r;
  assign hue_den_a[0] = hue_den2_r;
  assign hue_quo_a[0] = '0;
  assign sat_rem_a[0] = sat_rem2_r;
  assign sat_low_a[0] = sat_low2_r;
  assign sat_div_a[0] = sat_div2_r;
  assign sat_quo_a[0] = '0;
  assign value_a[0]   = value2_r;

  // Divider stages.
  for (genvar i = 0; i < ND; i++) begin : g_div
    rgbhsv_div_stage #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .HUE_BITS       (HUE_BITS),
      .FIRST_STEP     (i * STEPS_PER_STAGE)
    ) u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .in_valid    (v_a[i]),
      .in_ready    (rdy_a[i]),
      .in_hue_rem  (hue_rem_a[i]),
      .in_hue_den  (hue_den_a[i]),
      .in_hue_quo  (hue_quo_a[i]),
      .in_sat_rem  (sat_rem_a[i]),
      .in_sat_low  (sat_low_a[i]),
      .in_sat_div  (sat_div_a[i]),
      .in_sat_quo  (sat_quo_a[i]),
      .in_value    (value_a[i]),
      .out_valid   (v_a[i+1]),
      .out_ready   (rdy_a[i+1]),
      .out_hue_rem (hue_rem_a[i+1]),
      .out_hue_den (hue_den_a[i+1]),
      .out_hue_quo (hue_quo_a[i+1]),
      .out_sat_rem (sat_rem_a[i+1]),
      .out_sat_low (sat_low_a[i+1]),
      .out_sat_div (sat_div_a[i+1]),
      .out_sat_quo (sat_quo_a[i+1]),
      .out_value   (value_a[i+1])
    );
  end

  // Result beat comes straight from the last stage's registers.
  assign rdy_a[ND]              = out_hsv.ready;
  assign out_hsv.valid          = v_a[ND];
  assign out_hsv.hue_out        = hue_quo_a[ND];
  assign out_hsv.saturation_out = sat_quo_a[ND];
  assign out_hsv.value_out      = value_a[ND];

endmodule : rgb_to_hsv_converter_core
`default_nettype wire
